// File: rtl/core/tdrr_pkg.sv
// Shared types, constants and codes of the tiered DRR die wait scheduler.
package tdrr_pkg;

    // Sizing of the waiter FIFOs.
    localparam int FIFO_DEPTH  = 16;
    localparam int ID_BITS     = 8;
    localparam int NPRIO       = 6;
    localparam int PTR_W       = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int STORE_DEPTH = NPRIO * FIFO_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Fixed field widths.
    localparam int PRIO_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int WID_W      = 8;
    localparam int TIME_W     = 48;
    localparam int EMA_W      = 56;
    localparam int QUANT_W    = 8;
    localparam int WEIGHT_W   = 16;
    localparam int GRACE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Deficit counters.
    localparam int DEF_W   = 9;
    localparam int DEF_MAX = (1 << DEF_W) - 1;
    localparam int NDEF    = 4;

    // EMA arithmetic.
    localparam int WC_W       = WEIGHT_W + 1;
    localparam int MUL_A_W    = 32;
    localparam int PROD_W     = MUL_A_W + WC_W;
    localparam int ACC_W      = EMA_W + WEIGHT_W;
    localparam int MUL_SPLIT  = 32;
    localparam int ROUND_BIAS = 32768;
    localparam int FRAC_W     = 8;

    // Input mode codes.
    localparam logic MODE_ENQ   = 1'b0;
    localparam logic MODE_READY = 1'b1;

    // Priority codes.
    localparam logic [PRIO_W-1:0] PRIO_CRIT   = 3'd0;
    localparam logic [PRIO_W-1:0] PRIO_HREAD  = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_FGC    = 3'd2;
    localparam logic [PRIO_W-1:0] PRIO_HWRITE = 3'd3;
    localparam logic [PRIO_W-1:0] PRIO_NGC    = 3'd4;
    localparam logic [PRIO_W-1:0] PRIO_IDLE   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_Q2_S0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q2_S1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q3_S0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q3_S1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE  = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED   = 3'd0,
        ST_BAD_PRIO = 3'd1,
        ST_FULL     = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_HELD     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DECIDE,
        CS_FETCH,
        CS_MUL0,
        CS_MUL1,
        CS_MUL2,
        CS_MUL3,
        CS_ACC,
        CS_ROUND,
        CS_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MS_XLO,
        MS_YLO,
        MS_XHI,
        MS_YHI
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     decide;
        logic     fetch;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     ema_upd;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_ema;
    } dp_stat_t;

endpackage

// File: rtl/core/tdrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tdrr_ctrl.sv
// Sequencing state machine of the die wait scheduler.
module tdrr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tdrr_pkg::dp_cmd_t  cmd,
    input  tdrr_pkg::dp_stat_t stat
);

    import tdrr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // The result register can take a new result when it is empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_DECIDE;
                end
            end
            CS_DECIDE: state_next = CS_FETCH;
            CS_FETCH:  state_next = stat.need_ema ? CS_MUL0 : CS_DONE;
            CS_MUL0:   state_next = CS_MUL1;
            CS_MUL1:   state_next = CS_MUL2;
            CS_MUL2:   state_next = CS_MUL3;
            CS_MUL3:   state_next = CS_ACC;
            CS_ACC:    state_next = CS_ROUND;
            CS_ROUND:  state_next = CS_DONE;
            CS_DONE:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:   state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MS_XLO;
        in_ready    = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                // No input transfer is offered while reset is held.
                in_ready    = rst_n;
                cmd.capture = in_valid;
            end
            CS_DECIDE: cmd.decide = 1'b1;
            CS_FETCH:  cmd.fetch = 1'b1;
            CS_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_XLO;
                cmd.acc_clr = 1'b1;
            end
            CS_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_YLO;
                cmd.acc_add = 1'b1;
            end
            CS_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_XHI;
                cmd.acc_add = 1'b1;
            end
            CS_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_YHI;
                cmd.acc_add = 1'b1;
            end
            CS_ACC:    cmd.acc_add = 1'b1;
            CS_ROUND:  cmd.ema_upd = 1'b1;
            CS_DONE:   cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/tdrr_dpath.sv
// Datapath of the die wait scheduler: FIFO bookkeeping, pick logic, EMA and result.
module tdrr_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tdrr_pkg::dp_cmd_t                   cmd,
    output tdrr_pkg::dp_stat_t                  stat,
    input  logic                                cfg_write_en,
    input  logic [tdrr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdrr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                mode,
    input  logic [tdrr_pkg::PRIO_W-1:0]         priority_req,
    input  logic [tdrr_pkg::WID_W-1:0]          waiter_id,
    input  logic [tdrr_pkg::TIME_W-1:0]         now_ns,
    output logic [tdrr_pkg::STATUS_W-1:0]       status,
    output logic [tdrr_pkg::WID_W-1:0]          woken_id,
    output logic [tdrr_pkg::PRIO_W-1:0]         woken_priority,
    output logic [tdrr_pkg::EMA_W-1:0]          ema_interval
);

    import tdrr_pkg::*;

    // Returns the pair {a, b} after serving slot s and renormalizing.
    function automatic logic [2*DEF_W-1:0] def_update(
        input logic [DEF_W-1:0]   a,
        input logic [DEF_W-1:0]   b,
        input logic [QUANT_W-1:0] qa,
        input logic [QUANT_W-1:0] qb,
        input logic               s
    );
        logic [DEF_W:0] na;
        logic [DEF_W:0] nb;
        logic [DEF_W:0] m;
        logic [DEF_W:0] ra;
        logic [DEF_W:0] rb;
        logic [DEF_W-1:0] sa;
        logic [DEF_W-1:0] sb;
        na = {1'b0, a} + (s ? '0 : (DEF_W+1)'(qa));
        nb = {1'b0, b} + (s ? (DEF_W+1)'(qb) : '0);
        m  = (na < nb) ? na : nb;
        ra = na - m;
        rb = nb - m;
        sa = (ra > (DEF_W+1)'(DEF_MAX)) ? DEF_W'(DEF_MAX) : ra[DEF_W-1:0];
        sb = (rb > (DEF_W+1)'(DEF_MAX)) ? DEF_W'(DEF_MAX) : rb[DEF_W-1:0];
        return {sa, sb};
    endfunction

    // Configuration registers.
    logic [QUANT_W-1:0]  quant_reg [NDEF];
    logic [WEIGHT_W-1:0] weight_reg;
    logic [GRACE_W-1:0]  grace_reg;

    // Scheduler state.
    logic [CNT_W-1:0]  count_reg [NPRIO];
    logic [CNT_W-1:0]  count_next [NPRIO];
    logic [PTR_W-1:0]  head_reg [NPRIO];
    logic [PTR_W-1:0]  head_next [NPRIO];
    logic [DEF_W-1:0]  def_reg [NDEF];
    logic [DEF_W-1:0]  def_next [NDEF];
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [EMA_W-1:0]  ema_reg;
    logic [EMA_W-1:0]  ema_next;
    logic              need_ema_reg;
    logic              need_ema_next;
    logic              wake_reg;
    logic              wake_next;

    // Captured item and working registers.
    logic                in_mode_reg;
    logic [PRIO_W-1:0]   in_prio_reg;
    logic [ID_BITS-1:0]  in_id_reg;
    logic [TIME_W-1:0]   in_now_reg;
    status_t             res_status_reg;
    status_t             res_status_next;
    logic [PRIO_W-1:0]   res_prio_reg;
    logic [PRIO_W-1:0]   res_prio_next;
    logic [ID_BITS-1:0]  res_id_reg;
    logic [TIME_W-1:0]   iat_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                prod_hi_reg;
    logic [ACC_W-1:0]    acc_reg;

    // Result register.
    status_t             out_status_reg;
    logic [ID_BITS-1:0]  out_id_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [EMA_W-1:0]    out_ema_reg;

    // Waiter store port signals.
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ID_BITS-1:0]  ram_rdata;

    // Pick logic.
    logic [NPRIO-1:0]    nz;
    logic                t2_ok;
    logic                t2_s;
    logic                t3_ok;
    logic                t3_s;
    logic [2*DEF_W-1:0]  t2_upd;
    logic [2*DEF_W-1:0]  t3_upd;
    logic [TIME_W:0]     age_diff;
    logic [TIME_W-1:0]   age;
    logic                burst;
    logic                pick_wake;
    logic [PRIO_W-1:0]   pick_prio;
    status_t             pick_status;
    logic                pick_host;
    logic [PTR_W-1:0]    pick_head;
    logic [PTR_W-1:0]    head_inc;

    // Enqueue logic.
    logic                enq_prio_ok;
    logic [PRIO_W-1:0]   enq_idx;
    logic                enq_full;
    logic [CNT_W:0]      tail_sum;
    logic [CNT_W:0]      tail_slot;

    // EMA multiplier.
    logic [WC_W-1:0]     wc;
    logic [MUL_A_W-1:0]  mul_a;
    logic [WC_W-1:0]     mul_b;
    logic [TIME_W:0]     iat_diff;

    tdrr_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- pick ----------------
    always_comb
    begin
        for (int i = 0; i < NPRIO; i++)
        begin
            nz[i] = count_reg[i] != '0;
        end
    end

    assign t2_ok = nz[PRIO_HREAD] || nz[PRIO_FGC];
    assign t2_s  = (nz[PRIO_HREAD] && nz[PRIO_FGC]) ? (def_reg[0] > def_reg[1])
                                                    : !nz[PRIO_HREAD];
    assign t3_ok = nz[PRIO_HWRITE] || nz[PRIO_NGC];
    assign t3_s  = (nz[PRIO_HWRITE] && nz[PRIO_NGC]) ? (def_reg[2] > def_reg[3])
                                                     : !nz[PRIO_HWRITE];
    assign t2_upd = def_update(def_reg[0], def_reg[1], quant_reg[0], quant_reg[1], t2_s);
    assign t3_upd = def_update(def_reg[2], def_reg[3], quant_reg[2], quant_reg[3], t3_s);

    assign age_diff = {1'b0, in_now_reg} - {1'b0, last_reg};
    assign age      = age_diff[TIME_W] ? '0 : age_diff[TIME_W-1:0];
    assign burst    = (last_reg != '0) && (age < TIME_W'(grace_reg));

    always_comb
    begin
        pick_wake   = 1'b0;
        pick_prio   = PRIO_CRIT;
        pick_status = ST_EMPTY;
        priority if (nz[PRIO_CRIT])
        begin
            pick_wake = 1'b1;
        end
        else if (t2_ok)
        begin
            pick_wake = 1'b1;
            pick_prio = t2_s ? PRIO_FGC : PRIO_HREAD;
        end
        else if (t3_ok)
        begin
            pick_wake = 1'b1;
            pick_prio = t3_s ? PRIO_NGC : PRIO_HWRITE;
        end
        else if (nz[PRIO_IDLE] && !burst)
        begin
            pick_wake = 1'b1;
            pick_prio = PRIO_IDLE;
        end
        else if (nz[PRIO_IDLE])
        begin
            pick_status = ST_HELD;
        end
        else
        begin
            pick_status = ST_EMPTY;
        end
        if (pick_wake)
        begin
            pick_status = ST_WOKEN;
        end
    end

    assign pick_host = (pick_prio == PRIO_HREAD) || (pick_prio == PRIO_HWRITE);
    assign pick_head = head_reg[pick_prio];
    assign head_inc  = (pick_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : pick_head + 1'b1;
    assign ram_raddr = ADDR_W'(ADDR_W'(pick_prio) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(pick_head);

    // ---------------- enqueue ----------------
    assign enq_prio_ok = in_prio_reg <= PRIO_IDLE;
    assign enq_idx     = enq_prio_ok ? in_prio_reg : PRIO_CRIT;
    assign enq_full    = count_reg[enq_idx] >= CNT_W'(FIFO_DEPTH);
    assign tail_sum    = (CNT_W+1)'(head_reg[enq_idx]) + (CNT_W+1)'(count_reg[enq_idx]);
    assign tail_slot   = (tail_sum >= (CNT_W+1)'(FIFO_DEPTH))
                         ? tail_sum - (CNT_W+1)'(FIFO_DEPTH) : tail_sum;
    assign ram_waddr   = ADDR_W'(ADDR_W'(enq_idx) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(tail_slot);

    // ---------------- state update ----------------
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        def_next        = def_reg;
        last_next       = last_reg;
        ema_next        = ema_reg;
        need_ema_next   = need_ema_reg;
        wake_next       = wake_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        if (cmd.decide)
        begin
            need_ema_next = 1'b0;
            wake_next     = 1'b0;
            res_prio_next = PRIO_CRIT;
            if (in_mode_reg == MODE_ENQ)
            begin
                priority if (!enq_prio_ok)
                begin
                    res_status_next = ST_BAD_PRIO;
                end
                else if (enq_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we              = 1'b1;
                    count_next[enq_idx] = count_reg[enq_idx] + 1'b1;
                    res_status_next     = ST_QUEUED;
                end
            end
            else
            begin
                res_status_next = pick_status;
                if (pick_wake)
                begin
                    ram_re                = 1'b1;
                    wake_next             = 1'b1;
                    res_prio_next         = pick_prio;
                    head_next[pick_prio]  = head_inc;
                    count_next[pick_prio] = count_reg[pick_prio] - 1'b1;
                    if (pick_prio == PRIO_HREAD || pick_prio == PRIO_FGC)
                    begin
                        def_next[0] = t2_upd[2*DEF_W-1:DEF_W];
                        def_next[1] = t2_upd[DEF_W-1:0];
                    end
                    if (pick_prio == PRIO_HWRITE || pick_prio == PRIO_NGC)
                    begin
                        def_next[2] = t3_upd[2*DEF_W-1:DEF_W];
                        def_next[3] = t3_upd[DEF_W-1:0];
                    end
                    if (pick_host)
                    begin
                        // The first recorded host IO only sets the time base.
                        if (last_reg == '0)
                        begin
                            last_next = in_now_reg;
                            ema_next  = '0;
                        end
                        else
                        begin
                            need_ema_next = 1'b1;
                        end
                    end
                end
            end
        end
        if (cmd.ema_upd)
        begin
            if (ema_reg == '0)
            begin
                ema_next = {iat_reg, FRAC_W'(0)};
            end
            else
            begin
                ema_next = acc_reg[ACC_W-1 -: EMA_W];
            end
            last_next = in_now_reg;
        end
    end

    assign stat.need_ema = need_ema_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPRIO; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
            for (int i = 0; i < NDEF; i++)
            begin
                def_reg[i]   <= '0;
                quant_reg[i] <= QUANT_W'(1);
            end
            weight_reg   <= WEIGHT_W'(8192);
            grace_reg    <= GRACE_W'(100000);
            last_reg     <= '0;
            ema_reg      <= '0;
            need_ema_reg <= 1'b0;
            wake_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            head_reg     <= head_next;
            def_reg      <= def_next;
            last_reg     <= last_next;
            ema_reg      <= ema_next;
            need_ema_reg <= need_ema_next;
            wake_reg     <= wake_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_Q2_S0:  quant_reg[0] <= cfg_data[QUANT_W-1:0];
                    CFG_Q2_S1:  quant_reg[1] <= cfg_data[QUANT_W-1:0];
                    CFG_Q3_S0:  quant_reg[2] <= cfg_data[QUANT_W-1:0];
                    CFG_Q3_S1:  quant_reg[3] <= cfg_data[QUANT_W-1:0];
                    CFG_WEIGHT: weight_reg   <= cfg_data[WEIGHT_W-1:0];
                    CFG_GRACE:  grace_reg    <= cfg_data[GRACE_W-1:0];
                    default:    weight_reg   <= weight_reg;
                endcase
            end
        end
    end

    // ---------------- EMA: four 32x17 partial products ----------------
    assign wc       = WC_W'(1 << WEIGHT_W) - WC_W'(weight_reg);
    assign iat_diff = {1'b0, in_now_reg} - {1'b0, last_reg};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_XLO:
            begin
                mul_a = ema_reg[MUL_A_W-1:0];
                mul_b = wc;
            end
            MS_YLO:
            begin
                mul_a = {iat_reg[MUL_A_W-FRAC_W-1:0], FRAC_W'(0)};
                mul_b = WC_W'(weight_reg);
            end
            MS_XHI:
            begin
                mul_a = MUL_A_W'(ema_reg[EMA_W-1:MUL_SPLIT]);
                mul_b = wc;
            end
            MS_YHI:
            begin
                mul_a = MUL_A_W'(iat_reg[TIME_W-1:MUL_SPLIT-FRAC_W]);
                mul_b = WC_W'(weight_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_mode_reg <= mode;
            in_prio_reg <= priority_req;
            in_id_reg   <= ID_BITS'(waiter_id);
            in_now_reg  <= now_ns;
        end
        res_status_reg <= res_status_next;
        res_prio_reg   <= res_prio_next;
        if (cmd.fetch)
        begin
            res_id_reg <= wake_reg ? ram_rdata : '0;
            iat_reg    <= iat_diff[TIME_W] ? '0 : iat_diff[TIME_W-1:0];
        end
        if (cmd.mul_en)
        begin
            prod_reg    <= PROD_W'(mul_a) * PROD_W'(mul_b);
            prod_hi_reg <= (cmd.mul_sel == MS_XHI) || (cmd.mul_sel == MS_YHI);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= ACC_W'(ROUND_BIAS);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + (prod_hi_reg ? (ACC_W'(prod_reg) << MUL_SPLIT)
                                              : ACC_W'(prod_reg));
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_prio_reg   <= res_prio_reg;
            out_ema_reg    <= ema_reg;
        end
    end

    assign status         = out_status_reg;
    assign woken_id       = WID_W'(out_id_reg);
    assign woken_priority = out_prio_reg;
    assign ema_interval   = out_ema_reg;

endmodule

// File: rtl/core/tiered_drr_die_wait_scheduler_top.sv
// Top level of the tiered strict-priority and deficit round robin die wait scheduler.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | mode, priority_req, waiter_id, now_ns
//  result   | out_valid / out_ready| status, woken_id, woken_priority, ema_interval
//  config   | cfg_write_en         | cfg_index, cfg_data (no wait, no read-back)
//
//  For an enqueue or a wake that does not touch the host average, the item passes through
//  decision, store read and result load before out_valid rises. A host wake that updates
//  the average also runs the EMA product between store read and result load, as four 32x17
//  partial products on one multiplier, followed by accumulation and rounding.
//  One item is in work at a time; the next transfer is taken once the result is loaded
//  into the output register, even while that result still waits for out_ready.
//  Reset is asynchronous and active low and needs no clearing pass: the waiter store
//  is only read at occupied entries. in_ready stays low while reset is held.
//
// The controller steps through capture, decision, store read, the optional EMA update
// and the result load. The datapath holds the FIFO heads and counts, the deficit pairs,
// the host time and average, the configuration registers and the waiter store.
module tiered_drr_die_wait_scheduler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [tdrr_pkg::PRIO_W-1:0]         priority_req,
    input  logic [tdrr_pkg::WID_W-1:0]          waiter_id,
    input  logic [tdrr_pkg::TIME_W-1:0]         now_ns,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tdrr_pkg::STATUS_W-1:0]       status,
    output logic [tdrr_pkg::WID_W-1:0]          woken_id,
    output logic [tdrr_pkg::PRIO_W-1:0]         woken_priority,
    output logic [tdrr_pkg::EMA_W-1:0]          ema_interval,
    input  logic                                cfg_write_en,
    input  logic [tdrr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdrr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tdrr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: owns the handshakes and issues one command set per cycle.
    tdrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: all scheduler state, the waiter store and the result register.
    tdrr_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .priority_req   (priority_req),
        .waiter_id      (waiter_id),
        .now_ns         (now_ns),
        .status         (status),
        .woken_id       (woken_id),
        .woken_priority (woken_priority),
        .ema_interval   (ema_interval)
    );

endmodule
